// ----- sv/fcp_pkg.sv -----
// Shared types and constants for the frustum corner points unit.
`timescale 1ns / 1ps
`default_nettype none
package fcp_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned REG_W   = 31;

  typedef enum logic [2:0] {
    REG_NEAR_DIST = 3'd0,
    REG_FAR_DIST  = 3'd1,
    REG_NEAR_HW   = 3'd2,
    REG_NEAR_HH   = 3'd3,
    REG_FAR_HW    = 3'd4,
    REG_FAR_HH    = 3'd5
  } cfg_reg_t;

  localparam logic [REG_W-1:0] RST_NEAR_DIST = 31'd65536;
  localparam logic [REG_W-1:0] RST_FAR_DIST  = 31'd6553600;
  localparam logic [REG_W-1:0] RST_NEAR_HW   = 31'd65536;
  localparam logic [REG_W-1:0] RST_NEAR_HH   = 31'd65536;
  localparam logic [REG_W-1:0] RST_FAR_HW    = 31'd6553600;
  localparam logic [REG_W-1:0] RST_FAR_HH    = 31'd6553600;

  typedef struct packed {
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] look_x;
    logic signed [31:0] look_y;
    logic signed [31:0] look_z;
    logic signed [31:0] upward_x;
    logic signed [31:0] upward_y;
    logic signed [31:0] upward_z;
  } in_t;

  typedef struct packed {
    logic [2:0]         corner_index;
    logic signed [31:0] corner_x;
    logic signed [31:0] corner_y;
    logic signed [31:0] corner_z;
    logic               degenerate;
    logic               last_corner;
  } out_t;

  // Camera basis handed from the front end to the corner emitter.
  typedef struct packed {
    logic [2:0][COORD_W-1:0] eye;
    logic [2:0][COORD_W-1:0] look;
    logic [2:0][COORD_W-1:0] rt;
    logic [2:0][COORD_W-1:0] up;
    logic                    degen;
  } frame_t;

  typedef struct packed {
    logic [REG_W-1:0] near_dist;
    logic [REG_W-1:0] far_dist;
    logic [REG_W-1:0] near_hw;
    logic [REG_W-1:0] near_hh;
    logic [REG_W-1:0] far_hw;
    logic [REG_W-1:0] far_hh;
  } cfg_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic full;
    logic empty;
  } q_ctl_t;

endpackage
`default_nettype wire

// ----- sv/frustum_corner_points_unit.sv -----
// Top level: configuration registers, front end, frame queue and corner emitter.
//
// Usage: present one camera pose (eye point, view direction, approximate up
// vector, signed Q16.16) on the in_ channel with valid/ready; each accepted
// transaction yields eight corner transactions on the out_ channel, near
// plane corners 0..3 then far plane corners 4..7, last_corner on the eighth.
// The plane distances and half extents are written through the cfg_ port
// (index 0..5, higher indexes ignored); the user must do so only while the
// block is idle, as the block itself does not enforce it.
// Steps: the front end forms each of its two unit vectors in turn by a cross
// product, a common block shift, three squares summed, the one-bit-per-cycle
// square root and the three parallel divider lanes, then pushes the frame; a
// zero cross product skips the squares, root and divide for that vector.
// The emitter then, for each plane, scales the basis on its single multiplier
// and emits that plane's four corners, one per cycle while the receiver takes
// them.
// A one-entry input buffer takes the next pose while the front end works,
// and a two-entry frame queue lets the front end run ahead of the emitter.
// When the receiver stalls the output register holds its corner; the emitter
// and then the queue and front end back up in turn.
// Reset (synchronous, active low) empties every stage and restores the
// register defaults; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module frustum_corner_points_unit
  import fcp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_t              in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_t                  out_data,
  input  wire logic             cfg_we,
  input  wire logic [2:0]       cfg_index,
  input  wire logic [REG_W-1:0] cfg_wdata
);

  cfg_t   cfg_r;
  q_ctl_t qc;
  frame_t push_frame;
  frame_t head_frame;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.near_dist <= RST_NEAR_DIST;
      cfg_r.far_dist  <= RST_FAR_DIST;
      cfg_r.near_hw   <= RST_NEAR_HW;
      cfg_r.near_hh   <= RST_NEAR_HH;
      cfg_r.far_hw    <= RST_FAR_HW;
      cfg_r.far_hh    <= RST_FAR_HH;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_NEAR_DIST: cfg_r.near_dist <= cfg_wdata;
        REG_FAR_DIST:  cfg_r.far_dist  <= cfg_wdata;
        REG_NEAR_HW:   cfg_r.near_hw   <= cfg_wdata;
        REG_NEAR_HH:   cfg_r.near_hh   <= cfg_wdata;
        REG_FAR_HW:    cfg_r.far_hw    <= cfg_wdata;
        REG_FAR_HH:    cfg_r.far_hh    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  fcp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (qc.full),
    .q_push   (qc.push),
    .q_frame  (push_frame)
  );

  fcp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (qc.push),
    .push_data (push_frame),
    .pop       (qc.pop),
    .head      (head_frame),
    .full      (qc.full),
    .empty     (qc.empty)
  );

  fcp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (qc.empty),
    .q_head    (head_frame),
    .q_pop     (qc.pop),
    .cfg       (cfg_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(qc.push && qc.full))
    else $error("frame queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(qc.pop && qc.empty))
    else $error("frame queue pop while empty");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last_corner == (out_data.corner_index == 3'd7)))
    else $error("last_corner does not match corner index");

  a_pop_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    qc.pop |=> (out_valid && out_data.last_corner))
    else $error("frame released before its last corner");

endmodule
`default_nettype wire

// ----- sv/fcp_front.sv -----
// Front end: takes a pose, forms the right and true-up unit vectors.
`timescale 1ns / 1ps
`default_nettype none
module fcp_front
  import fcp_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire in_t    in_data,
  input  wire logic   q_full,
  output logic        q_push,
  output frame_t      q_frame
);

  typedef enum logic [6:0] {
    F_IDLE   = 7'b0000001,
    F_CROSS  = 7'b0000010,
    F_SCALE  = 7'b0000100,
    F_SQUARE = 7'b0001000,
    F_ROOT   = 7'b0010000,
    F_DIVIDE = 7'b0100000,
    F_PUSH   = 7'b1000000
  } fstate_t;

  fstate_t state_r;
  logic    hold_valid_r;
  in_t     hold_r;
  logic    pass_r;
  logic    degen_r;
  logic [4:0] step_r;

  logic signed [31:0] eye_r [3];
  logic signed [31:0] look_r [3];
  logic signed [31:0] upw_r [3];
  logic signed [31:0] rt_r [3];
  logic signed [31:0] up_r [3];

  logic signed [63:0] prod_r;
  logic signed [63:0] first_r;
  logic [63:0] mag_r [3];
  logic        neg_r [3];
  logic [51:0] sum_r;
  logic [51:0] rad_r;
  logic [51:0] root_r;
  logic [51:0] bit_r;
  logic [26:0] rem_r [3];
  logic [30:0] quo_r [3];

  logic signed [31:0] a_v [3];
  logic signed [31:0] b_v [3];
  logic signed [31:0] op_a, op_b;
  logic signed [63:0] mul_p;
  logic [2:0]  cs;
  logic signed [63:0] diff;
  logic [63:0] diff_mag;
  logic any8, any1, low8, low1, all_zero;
  logic [51:0] rtry;
  logic [25:0] len;
  logic [26:0] dt [3];
  logic        ge [3];
  logic [26:0] rnext [3];
  logic [30:0] qn [3];
  logic signed [31:0] unit [3];

  assign in_ready = !hold_valid_r;
  assign mul_p    = op_a * op_b;
  assign cs       = step_r[2:0] - 3'd1;
  assign diff     = first_r - prod_r;
  assign diff_mag = diff[63] ? (64'd0 - diff) : diff;
  assign rtry     = root_r + bit_r;
  assign len      = root_r[25:0];
  assign q_push   = (state_r == F_PUSH) && !q_full;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_v[i] = pass_r ? rt_r[i] : look_r[i];
      b_v[i] = pass_r ? look_r[i] : upw_r[i];
    end
  end

  always_comb begin
    op_a = '0;
    op_b = '0;
    if (state_r == F_CROSS) begin
      unique case (step_r[2:0])
        3'd0: begin op_a = a_v[1]; op_b = b_v[2]; end
        3'd1: begin op_a = a_v[2]; op_b = b_v[1]; end
        3'd2: begin op_a = a_v[2]; op_b = b_v[0]; end
        3'd3: begin op_a = a_v[0]; op_b = b_v[2]; end
        3'd4: begin op_a = a_v[0]; op_b = b_v[1]; end
        3'd5: begin op_a = a_v[1]; op_b = b_v[0]; end
        default: begin op_a = '0; op_b = '0; end
      endcase
    end else if (state_r == F_SQUARE && step_r[1:0] != 2'd3) begin
      op_a = $signed({7'd0, mag_r[step_r[1:0]][24:0]});
      op_b = op_a;
    end
  end

  // Range tests for the common block shift.
  always_comb begin
    any8 = 1'b0; any1 = 1'b0; low8 = 1'b1; low1 = 1'b1; all_zero = 1'b1;
    for (int i = 0; i < 3; i++) begin
      any8     = any8 | (|mag_r[i][63:33]);
      any1     = any1 | (|mag_r[i][63:25]);
      low8     = low8 & !(|mag_r[i][63:16]);
      low1     = low1 & !(|mag_r[i][63:24]);
      all_zero = all_zero & (mag_r[i] == 64'd0);
    end
  end

  // Three restoring divider lanes, one quotient bit each per cycle.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dt[i]    = (step_r == 5'd0) ? rem_r[i] : {rem_r[i][25:0], 1'b0};
      ge[i]    = dt[i] >= {1'b0, len};
      rnext[i] = ge[i] ? (dt[i] - {1'b0, len}) : dt[i];
      qn[i]    = {quo_r[i][29:0], ge[i]};
      unit[i]  = neg_r[i] ? -$signed({1'b0, qn[i]}) : $signed({1'b0, qn[i]});
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q_frame.eye[i]  = eye_r[i];
      q_frame.look[i] = look_r[i];
      q_frame.rt[i]   = rt_r[i];
      q_frame.up[i]   = up_r[i];
    end
    q_frame.degen = degen_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= F_IDLE;
      hold_valid_r <= 1'b0;
      pass_r       <= 1'b0;
      step_r       <= '0;
      degen_r      <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        hold_r       <= in_data;
        hold_valid_r <= 1'b1;
      end
      prod_r <= mul_p;
      unique case (state_r)
        F_IDLE: begin
          if (hold_valid_r) begin
            eye_r[0] <= hold_r.eye_x;    eye_r[1] <= hold_r.eye_y;
            eye_r[2] <= hold_r.eye_z;
            look_r[0] <= hold_r.look_x;  look_r[1] <= hold_r.look_y;
            look_r[2] <= hold_r.look_z;
            upw_r[0] <= hold_r.upward_x; upw_r[1] <= hold_r.upward_y;
            upw_r[2] <= hold_r.upward_z;
            hold_valid_r <= 1'b0;
            pass_r  <= 1'b0;
            degen_r <= 1'b0;
            step_r  <= '0;
            state_r <= F_CROSS;
          end
        end
        F_CROSS: begin
          if (step_r != 5'd0) begin
            if (!cs[0]) begin
              first_r <= prod_r;
            end else begin
              mag_r[cs[2:1]] <= diff_mag;
              neg_r[cs[2:1]] <= diff[63];
            end
          end
          step_r <= step_r + 5'd1;
          if (step_r == 5'd6) begin
            step_r  <= '0;
            state_r <= F_SCALE;
          end
        end
        F_SCALE: begin
          priority if (all_zero) begin
            // Zero-length cross product: unit vector is zero.
            degen_r <= 1'b1;
            for (int i = 0; i < 3; i++) begin
              if (!pass_r) rt_r[i] <= '0;
              else         up_r[i] <= '0;
            end
            step_r  <= '0;
            pass_r  <= 1'b1;
            state_r <= pass_r ? F_PUSH : F_CROSS;
          end else if (any8) begin
            for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> 8;
          end else if (any1) begin
            for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> 1;
          end else if (low8) begin
            for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] << 8;
          end else if (low1) begin
            for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] << 1;
          end else begin
            step_r  <= '0;
            state_r <= F_SQUARE;
          end
        end
        F_SQUARE: begin
          step_r <= step_r + 5'd1;
          if (step_r == 5'd1) sum_r <= prod_r[51:0];
          if (step_r == 5'd2) sum_r <= sum_r + prod_r[51:0];
          if (step_r == 5'd3) begin
            rad_r   <= sum_r + prod_r[51:0];
            root_r  <= '0;
            bit_r   <= 52'd1 << 50;
            state_r <= F_ROOT;
          end
        end
        F_ROOT: begin
          if (rad_r >= rtry) begin
            rad_r  <= rad_r - rtry;
            root_r <= (root_r >> 1) + bit_r;
          end else begin
            root_r <= root_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (bit_r[0]) begin
            for (int i = 0; i < 3; i++) begin
              rem_r[i] <= {2'b00, mag_r[i][24:0]};
              quo_r[i] <= '0;
            end
            step_r  <= '0;
            state_r <= F_DIVIDE;
          end
        end
        F_DIVIDE: begin
          for (int i = 0; i < 3; i++) begin
            rem_r[i] <= rnext[i];
            quo_r[i] <= qn[i];
          end
          step_r <= step_r + 5'd1;
          if (step_r == 5'd30) begin
            for (int i = 0; i < 3; i++) begin
              if (!pass_r) rt_r[i] <= unit[i];
              else         up_r[i] <= unit[i];
            end
            step_r  <= '0;
            pass_r  <= 1'b1;
            state_r <= pass_r ? F_PUSH : F_CROSS;
          end
        end
        F_PUSH: begin
          if (!q_full) state_r <= F_IDLE;
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- sv/fcp_queue.sv -----
// Two-entry queue of camera frames between the front end and the emitter.
`timescale 1ns / 1ps
`default_nettype none
module fcp_queue
  import fcp_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire frame_t push_data,
  input  wire logic   pop,
  output frame_t      head,
  output logic        full,
  output logic        empty
);

  frame_t     mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full  = count_r == 2'd2;
  assign empty = count_r == 2'd0;
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- sv/fcp_back.sv -----
// Back end: scales the basis per plane and emits the eight corners.
`timescale 1ns / 1ps
`default_nettype none
module fcp_back
  import fcp_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   q_empty,
  input  wire frame_t q_head,
  output logic        q_pop,
  input  wire cfg_t   cfg,
  output logic        out_valid,
  input  wire logic   out_ready,
  output out_t        out_data
);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_MUL  = 3'b010,
    B_EMIT = 3'b100
  } bstate_t;

  bstate_t    state_r;
  logic [3:0] step_r;
  logic [1:0] k_r;
  logic       plane_r;
  logic       out_valid_r;
  out_t       out_r;
  logic signed [63:0] prod_r;
  logic [31:0] ctr_r [3];
  logic [31:0] rw_r [3];
  logic [31:0] uh_r [3];

  logic signed [31:0] op_a, op_b;
  logic signed [63:0] mul_p;
  logic [3:0]  cs;
  logic [REG_W-1:0] plane_dist, hw, hh;
  logic        load;
  logic [31:0] b1 [3];
  logic [31:0] b2 [3];
  logic [31:0] pt [3];

  assign mul_p      = op_a * op_b;
  assign cs         = step_r - 4'd1;
  assign plane_dist = plane_r ? cfg.far_dist : cfg.near_dist;
  assign hw         = plane_r ? cfg.far_hw   : cfg.near_hw;
  assign hh         = plane_r ? cfg.far_hh   : cfg.near_hh;
  assign load       = (state_r == B_EMIT) && (!out_valid_r || out_ready);
  assign q_pop      = load && plane_r && (k_r == 2'd3);
  assign out_valid  = out_valid_r;
  assign out_data   = out_r;

  always_comb begin
    op_a = '0;
    op_b = '0;
    if (state_r == B_MUL) begin
      unique case (step_r)
        4'd0: begin op_a = q_head.look[0]; op_b = $signed({1'b0, plane_dist}); end
        4'd1: begin op_a = q_head.look[1]; op_b = $signed({1'b0, plane_dist}); end
        4'd2: begin op_a = q_head.look[2]; op_b = $signed({1'b0, plane_dist}); end
        4'd3: begin op_a = q_head.rt[0];   op_b = $signed({1'b0, hw});   end
        4'd4: begin op_a = q_head.rt[1];   op_b = $signed({1'b0, hw});   end
        4'd5: begin op_a = q_head.rt[2];   op_b = $signed({1'b0, hw});   end
        4'd6: begin op_a = q_head.up[0];   op_b = $signed({1'b0, hh});   end
        4'd7: begin op_a = q_head.up[1];   op_b = $signed({1'b0, hh});   end
        4'd8: begin op_a = q_head.up[2];   op_b = $signed({1'b0, hh});   end
        default: begin op_a = '0; op_b = '0; end
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      b1[i] = uh_r[i] - rw_r[i];
      b2[i] = uh_r[i] + rw_r[i];
      unique case (k_r)
        2'd0: pt[i] = ctr_r[i] - b1[i];
        2'd1: pt[i] = ctr_r[i] + b1[i];
        2'd2: pt[i] = ctr_r[i] + b2[i];
        2'd3: pt[i] = ctr_r[i] - b2[i];
        default: pt[i] = ctr_r[i];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r.corner_index <= {plane_r, k_r};
      out_r.corner_x     <= pt[0];
      out_r.corner_y     <= pt[1];
      out_r.corner_z     <= pt[2];
      out_r.degenerate   <= q_head.degen;
      out_r.last_corner  <= plane_r && (k_r == 2'd3);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      step_r      <= '0;
      k_r         <= '0;
      plane_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      prod_r <= mul_p;
      if (load)           out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            step_r  <= '0;
            plane_r <= 1'b0;
            state_r <= B_MUL;
          end
        end
        B_MUL: begin
          // Consume the registered product of the previous step.
          if (step_r != 4'd0) begin
            unique case (cs)
              4'd0: ctr_r[0] <= q_head.eye[0] + prod_r[47:16];
              4'd1: ctr_r[1] <= q_head.eye[1] + prod_r[47:16];
              4'd2: ctr_r[2] <= q_head.eye[2] + prod_r[47:16];
              4'd3: rw_r[0]  <= prod_r[61:30];
              4'd4: rw_r[1]  <= prod_r[61:30];
              4'd5: rw_r[2]  <= prod_r[61:30];
              4'd6: uh_r[0]  <= prod_r[61:30];
              4'd7: uh_r[1]  <= prod_r[61:30];
              4'd8: uh_r[2]  <= prod_r[61:30];
              default: ;
            endcase
          end
          step_r <= step_r + 4'd1;
          if (step_r == 4'd9) begin
            k_r     <= '0;
            state_r <= B_EMIT;
          end
        end
        B_EMIT: begin
          if (load) begin
            k_r <= k_r + 2'd1;
            if (k_r == 2'd3) begin
              step_r  <= '0;
              plane_r <= 1'b1;
              state_r <= plane_r ? B_IDLE : B_MUL;
            end
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
